### rtl/core/best_fit_heap_allocator_core_defines.svh
// assertion macros used by the allocator port checker
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BFHA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, disabled during reset
`define BFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### rtl/core/bfha_pkg.sv
// shared types and constants of the best-fit heap allocator
package bfha_pkg;

  // default sizing
  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;

  // heap limit register after reset
  localparam logic [16:0] LIMIT_RESET = 17'd65536;

  // request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_HEAP  = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // per-cycle operation applied to the whole row of cells
  typedef struct packed {
    logic rot;
    logic ins;
    logic rem;
    logic wr;
  } cell_op_t;

endpackage

### rtl/core/best_fit_heap_allocator_core.sv
// best-fit heap allocator: row of table cells plus scan and update control
//
// Input channel (in_valid / in_stall) carries one request beat: action
// (0 allocate, 1 free), alloc_bytes and payload_address. Output channel
// (out_valid / out_stall) returns one beat per request: address and status.
// cfg_we / cfg_wdata write the heap limit; write it only while idle.
// One request is handled at a time. Each request rotates the whole row of
// MAX_BLOCKS table cells past the head once, one cell per cycle, then
// applies its update to the row in S_COMMIT. A reused free block (split or
// whole) then passes S_INS, a free that succeeds passes S_R1, S_R2 and S_R3,
// and every request ends in S_DONE, which loads the result register. The
// next request is taken in the cycle after the result is loaded. The result
// register holds a beat while out_stall is high; a finished result waits
// until the register is free.
// Reset (rst, synchronous) empties the table, sets the break to 0 and the
// heap limit to 65536. No clearing pass is needed.
module best_fit_heap_allocator_core #(
  parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF,
  parameter int MAX_BLOCKS   = bfha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] alloc_bytes,
  input  logic [15:0] payload_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] address,
  output logic [2:0]  status,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);
  import bfha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int WW = ((AW > 17) ? AW : 17) + 2;
  localparam logic [WW-1:0] HDR  = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] HEAP = WW'(HEAP_BYTES);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BLOCKS);
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_BLOCKS - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_COMMIT = 8'b0000_0100,
    S_INS    = 8'b0000_1000,
    S_R1     = 8'b0001_0000,
    S_R2     = 8'b0010_0000,
    S_R3     = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  // control registers
  logic [IW-1:0] scan;
  logic [CW-1:0] count;
  logic [AW-1:0] brk;
  logic [16:0]   limit;
  logic          found, t_found, n_seen, n_free, p_free, split, last;

  // request and scan capture registers
  logic          req_act;
  logic [15:0]   req_size, req_addr;
  logic [IW-1:0] pick, t_idx;
  logic [AW-1:0] b_start, b_size, t_start, t_size;
  logic [AW-1:0] p_start, p_size, n_size;
  logic [AW-1:0] last_start, last_size;
  logic          last_used;
  logic [15:0]   res_addr;
  logic [2:0]    res_status;

  // cell row
  logic [AW-1:0] c_start [MAX_BLOCKS];
  logic [AW-1:0] c_size  [MAX_BLOCKS];
  logic          c_used  [MAX_BLOCKS];
  cell_op_t      op;
  logic [IW-1:0] op_pos;
  logic [AW-1:0] wd_start, wd_size;
  logic          wd_used;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    localparam int L = (k + MAX_BLOCKS - 1) % MAX_BLOCKS;
    localparam int R = (k + 1) % MAX_BLOCKS;
    bfha_cell #(.AW(AW), .IW(IW), .K(k)) u_cell (
      .clk(clk), .op(op), .pos(op_pos),
      .wr_start(wd_start), .wr_size(wd_size), .wr_used(wd_used),
      .left_start(c_start[L]), .left_size(c_size[L]), .left_used(c_used[L]),
      .right_start(c_start[R]), .right_size(c_size[R]), .right_used(c_used[R]),
      .start(c_start[k]), .size(c_size[k]), .used(c_used[k])
    );
  end

  // head of the row during the scan
  logic          live, cand, match;
  logic [WW-1:0] head_start_w, head_size_w, req_w;
  assign head_start_w = WW'(c_start[0]);
  assign head_size_w  = WW'(c_size[0]);
  assign req_w        = WW'(req_size);
  assign live  = CW'(scan) < count;
  assign cand  = live && !c_used[0] && head_size_w >= req_w;
  assign match = live && c_used[0] && (head_start_w + HDR == WW'(req_addr));

  // decision terms for the update
  logic          is_alloc, bad_size, fit_ok, app_ok, free_ok, do_split, is_last;
  logic [WW-1:0] need, lim_w, tsz2, msz;
  logic [AW-1:0] ms;
  logic [IW-1:0] lo;
  assign is_alloc = (req_act == ACT_ALLOC);
  assign bad_size = (req_size == 16'd0);
  assign need     = WW'(brk) + HDR + req_w;
  assign lim_w    = (WW'(limit) < HEAP) ? WW'(limit) : HEAP;
  assign fit_ok   = is_alloc && !bad_size && found;
  assign app_ok   = is_alloc && !bad_size && !found && !(need > lim_w) && count < CNT_MAX;
  assign free_ok  = !is_alloc && t_found;
  assign do_split = (WW'(b_size) > req_w + HDR) && count < CNT_MAX;
  assign tsz2     = WW'(t_size) + (n_free ? WW'(n_size) + HDR : '0);
  assign msz      = p_free ? WW'(p_size) + tsz2 + HDR : tsz2;
  assign ms       = p_free ? p_start : t_start;
  assign lo       = p_free ? t_idx - IW'(1) : t_idx;
  assign is_last  = !n_seen ||
                    (n_free && ((CW + 1)'(t_idx) + (CW + 1)'(2) == (CW + 1)'(count)));

  // row operation for each state
  always_comb begin
    op       = '0;
    op_pos   = '0;
    wd_start = '0;
    wd_size  = '0;
    wd_used  = 1'b0;
    case (state)
      S_SCAN: op.rot = 1'b1;
      S_COMMIT: begin
        if (fit_ok) begin
          op.wr    = 1'b1;
          op_pos   = pick;
          wd_start = b_start;
          wd_size  = do_split ? AW'(req_size) : b_size;
          wd_used  = 1'b1;
        end else if (app_ok) begin
          op.wr    = 1'b1;
          op_pos   = count[IW-1:0];
          wd_start = brk;
          wd_size  = AW'(req_size);
          wd_used  = 1'b1;
        end else if (free_ok) begin
          op.wr    = 1'b1;
          op_pos   = lo;
          wd_start = ms;
          wd_size  = AW'(msz);
        end
      end
      S_INS: begin
        op.ins   = split;
        op_pos   = pick + IW'(1);
        wd_start = AW'(WW'(b_start) + HDR + req_w);
        wd_size  = AW'(WW'(b_size) - req_w - HDR);
      end
      S_R1: begin
        op.rem = n_free;
        op_pos = t_idx + IW'(1);
      end
      S_R2: begin
        op.rem = p_free;
        op_pos = t_idx;
      end
      S_R3: begin
        op.rem = last;
        op_pos = lo;
      end
      default: ;
    endcase
  end

  assign in_stall = rst || (state != S_IDLE);

  // sequencer, table occupancy, break, limit and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan      <= '0;
      count     <= '0;
      brk       <= '0;
      limit     <= LIMIT_RESET;
      found     <= 1'b0;
      t_found   <= 1'b0;
      n_seen    <= 1'b0;
      n_free    <= 1'b0;
      p_free    <= 1'b0;
      split     <= 1'b0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      // result beat handshake
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state   <= S_SCAN;
            scan    <= '0;
            found   <= 1'b0;
            t_found <= 1'b0;
            n_seen  <= 1'b0;
            n_free  <= 1'b0;
            p_free  <= 1'b0;
          end
        end
        S_SCAN: begin
          if (is_alloc && cand && (!found || c_size[0] < b_size)) found <= 1'b1;
          if (!is_alloc && match && !t_found) begin
            t_found <= 1'b1;
            p_free  <= (scan != '0) && !last_used;
          end
          if (!is_alloc && live && t_found && !n_seen && scan == t_idx + IW'(1)) begin
            n_seen <= 1'b1;
            n_free <= !c_used[0];
          end
          scan <= scan + IW'(1);
          if (scan == IDX_LAST) state <= S_COMMIT;
        end
        S_COMMIT: begin
          split <= fit_ok && do_split;
          last  <= free_ok && is_last;
          if (fit_ok && do_split) count <= count + CW'(1);
          if (app_ok) begin
            count <= count + CW'(1);
            brk   <= AW'(need);
          end
          if (free_ok) begin
            count <= count - CW'(n_free) - CW'(p_free) - CW'(is_last);
            if (is_last) brk <= ms;
          end
          if (fit_ok) state <= S_INS;
          else if (free_ok) state <= S_R1;
          else state <= S_DONE;
        end
        S_INS: state <= S_DONE;
        S_R1:  state <= S_R2;
        S_R2:  state <= S_R3;
        S_R3:  state <= S_DONE;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture, scan capture and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_act  <= action;
      req_size <= alloc_bytes;
      req_addr <= payload_address;
    end
    if (state == S_SCAN) begin
      last_start <= c_start[0];
      last_size  <= c_size[0];
      last_used  <= c_used[0];
      if (is_alloc && cand && (!found || c_size[0] < b_size)) begin
        pick    <= scan;
        b_start <= c_start[0];
        b_size  <= c_size[0];
      end
      if (!is_alloc && match && !t_found) begin
        t_idx   <= scan;
        t_start <= c_start[0];
        t_size  <= c_size[0];
        p_start <= last_start;
        p_size  <= last_size;
      end
      if (!is_alloc && live && t_found && !n_seen && scan == t_idx + IW'(1)) begin
        n_size <= c_size[0];
      end
    end
    if (state == S_COMMIT) begin
      if (is_alloc) begin
        if (bad_size) res_status <= ST_BAD_SIZE;
        else if (found) res_status <= ST_OK;
        else if (need > lim_w) res_status <= ST_NO_HEAP;
        else if (!(count < CNT_MAX)) res_status <= ST_FULL;
        else res_status <= ST_OK;
      end else begin
        res_status <= t_found ? ST_OK : ST_BAD_ADDR;
      end
      if (fit_ok) res_addr <= 16'((WW'(b_start) + HDR));
      else if (app_ok) res_addr <= 16'((WW'(brk) + HDR));
      else res_addr <= 16'd0;
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      address <= res_addr;
      status  <= res_status;
    end
  end

endmodule

### rtl/core/bfha_cell.sv
// one block-table entry of the cell row
module bfha_cell #(
  parameter int AW = 17,
  parameter int IW = 6,
  parameter int K  = 0
) (
  input  logic               clk,
  input  bfha_pkg::cell_op_t op,
  input  logic [IW-1:0]      pos,
  input  logic [AW-1:0]      wr_start,
  input  logic [AW-1:0]      wr_size,
  input  logic               wr_used,
  input  logic [AW-1:0]      left_start,
  input  logic [AW-1:0]      left_size,
  input  logic               left_used,
  input  logic [AW-1:0]      right_start,
  input  logic [AW-1:0]      right_size,
  input  logic               right_used,
  output logic [AW-1:0]      start,
  output logic [AW-1:0]      size,
  output logic               used
);
  import bfha_pkg::*;

  localparam logic [IW-1:0] MY_POS = IW'(K);

  // rotate toward the head, open a slot, close a slot, or overwrite
  always_ff @(posedge clk) begin
    if (op.rot) begin
      start <= right_start;
      size  <= right_size;
      used  <= right_used;
    end else if (op.ins) begin
      if (MY_POS > pos) begin
        start <= left_start;
        size  <= left_size;
        used  <= left_used;
      end else if (MY_POS == pos) begin
        start <= wr_start;
        size  <= wr_size;
        used  <= wr_used;
      end
    end else if (op.rem) begin
      if (MY_POS >= pos) begin
        start <= right_start;
        size  <= right_size;
        used  <= right_used;
      end
    end else if (op.wr && MY_POS == pos) begin
      start <= wr_start;
      size  <= wr_size;
      used  <= wr_used;
    end
  end

endmodule

### rtl/core/bfha_checker.sv
// port-level checks of the allocator and their binding
`include "best_fit_heap_allocator_core_defines.svh"

module bfha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] address,
  input logic [2:0]  status
);
  import bfha_pkg::*;

  // status is one of the defined codes
  `BFHA_ASSERT_NOW(a_status_code, clk, rst, out_valid, status <= ST_FULL)

  // a failed request never returns an address
  `BFHA_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && status != ST_OK, address == 16'd0)

  // one request in flight: an accepted beat closes the input
  `BFHA_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)

  // a stalled result beat holds
  `BFHA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(address) && $stable(status))

endmodule

bind best_fit_heap_allocator_core bfha_checker u_bfha_checker (.*);

### tb/bfha_checker.sv
// checker for the best-fit heap allocator: predicts each result and compares
module bfha_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [15:0] alloc_bytes,
  input  logic [15:0] payload_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] address,
  input  logic [2:0]  status,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  output int          fail_count,
  output int          owed
);
  import bfha_pkg::*;

  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam int HDR  = HEADER_BYTES_DEF;
  localparam int ARENA = HEAP_BYTES_DEF;

  typedef struct {
    bit [15:0] addr;
    bit [2:0]  st;
  } grant_t;

  // mirror of the block table and heap registers
  bit [16:0] blk_start [NBLK];
  bit [16:0] blk_size  [NBLK];
  bit        blk_used  [NBLK];
  int        nblk;
  bit [16:0] brk;
  bit [16:0] limit_reg;

  grant_t grant_q[$];

  task automatic flag_mismatch(input string what, input int want, input int got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  function automatic void slot_insert(input int pos, input int s, input int z, input bit u);
    for (int k = nblk; k > pos; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_size[k]  = blk_size[k-1];
      blk_used[k]  = blk_used[k-1];
    end
    blk_start[pos] = 17'(s);
    blk_size[pos]  = 17'(z);
    blk_used[pos]  = u;
    nblk++;
  endfunction

  function automatic void slot_remove(input int pos);
    for (int k = pos; k + 1 < nblk; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_size[k]  = blk_size[k+1];
      blk_used[k]  = blk_used[k+1];
    end
    nblk--;
  endfunction

  // best fit search, split, or append at the break
  function automatic grant_t grant_alloc(input int req);
    grant_t g;
    int pick, lim, need;
    bit hit;
    g.addr = '0;
    pick = 0;
    hit = 0;
    if (req == 0) begin
      g.st = ST_BAD_SIZE;
      return g;
    end
    for (int i = 0; i < nblk; i++) begin
      if (!blk_used[i] && blk_size[i] >= req) begin
        if (blk_size[i] == req) begin
          pick = i;
          hit = 1;
          break;
        end
        if (!hit || blk_size[pick] > blk_size[i]) begin
          pick = i;
          hit = 1;
        end
      end
    end
    if (hit) begin
      blk_used[pick] = 1;
      if (blk_size[pick] > req + HDR && nblk < NBLK) begin
        slot_insert(pick + 1, blk_start[pick] + HDR + req, blk_size[pick] - req - HDR, 0);
        blk_size[pick] = 17'(req);
      end
      g.addr = 16'(blk_start[pick] + HDR);
      g.st = ST_OK;
      return g;
    end
    lim = (limit_reg < ARENA) ? limit_reg : ARENA;
    need = brk + HDR + req;
    if (need > lim) begin
      g.st = ST_NO_HEAP;
      return g;
    end
    if (nblk >= NBLK) begin
      g.st = ST_FULL;
      return g;
    end
    slot_insert(nblk, brk, req, 1);
    g.addr = 16'(brk + HDR);
    g.st = ST_OK;
    brk = 17'(need);
    return g;
  endfunction

  // release a used block, merge free neighbours, shrink at the top
  function automatic grant_t grant_free(input int pa);
    grant_t g;
    int pos;
    bit hit;
    g.addr = '0;
    g.st = ST_BAD_ADDR;
    pos = 0;
    hit = 0;
    if (pa == 0) return g;
    for (int i = 0; i < nblk; i++) begin
      if (blk_used[i] && blk_start[i] + HDR == pa) begin
        pos = i;
        hit = 1;
        break;
      end
    end
    if (!hit) return g;
    blk_used[pos] = 0;
    if (pos + 1 < nblk && !blk_used[pos+1]) begin
      blk_size[pos] = 17'(blk_size[pos] + blk_size[pos+1] + HDR);
      slot_remove(pos + 1);
    end
    if (pos > 0 && !blk_used[pos-1]) begin
      blk_size[pos-1] = 17'(blk_size[pos-1] + blk_size[pos] + HDR);
      slot_remove(pos);
      pos--;
    end
    if (pos + 1 == nblk) begin
      brk = blk_start[pos];
      slot_remove(pos);
    end
    g.st = ST_OK;
    return g;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      nblk = 0;
      brk = '0;
      limit_reg = LIMIT_RESET;
      grant_q.delete();
      fail_count = 0;
      owed = 0;
    end else begin
      if (cfg_we) limit_reg = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          flag_mismatch("result beats pending", 0, 1);
        end else begin
          g = grant_q.pop_front();
          if (address !== g.addr) flag_mismatch("address", g.addr, address);
          if (status !== g.st) flag_mismatch("status", g.st, status);
        end
      end
      if (in_valid && !in_stall) begin
        if (action == ACT_ALLOC) g = grant_alloc(alloc_bytes);
        else g = grant_free(payload_address);
        grant_q.push_back(g);
      end
      owed = grant_q.size();
    end
  end

endmodule

### tb/tb_best_fit_heap_allocator_core.sv
// testbench top: request stimulus, heap limit phases and verdict
module tb_best_fit_heap_allocator_core;
  import bfha_pkg::*;

  localparam int DRAIN_CYCLES = MAX_BLOCKS_DEF + 10;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic        action = ACT_ALLOC;
  logic [15:0] alloc_bytes = '0;
  logic [15:0] payload_address = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] address;
  logic [2:0]  status;
  logic        cfg_we = 0;
  logic [16:0] cfg_wdata = '0;

  int fail_count, owed;
  int idle_pct = 0, stall_pct = 0;
  bit out_hold = 0, hold_go = 0;
  int n_beats = 0;
  int st_seen[5] = '{default: 0};
  bit kind_q[$];
  bit [15:0] live_q[$];

  always #6 clk = ~clk;

  best_fit_heap_allocator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .alloc_bytes(alloc_bytes), .payload_address(payload_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .address(address), .status(status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  bfha_scoreboard u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .alloc_bytes(alloc_bytes), .payload_address(payload_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .address(address), .status(status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .owed(owed)
  );

  // receiver side stall
  always @(posedge clk) begin
    out_stall <= out_hold || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    out_hold <= 1;
    repeat (400) @(posedge clk);
    out_hold <= 0;
  end

  // track granted addresses so frees can target live blocks
  always @(posedge clk) begin
    bit k;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        kind_q.push_back(action);
        n_beats++;
      end
      if (out_valid && !out_stall && kind_q.size() > 0) begin
        k = kind_q.pop_front();
        if (status <= ST_FULL) st_seen[status]++;
        if (k == ACT_ALLOC && status == ST_OK) live_q.push_back(address);
      end
    end
  end

  // one request beat, held until accepted
  task automatic put_beat(input logic a, input logic [15:0] sz, input logic [15:0] pa);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action <= a;
    alloc_bytes <= sz;
    payload_address <= pa;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [16:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 16'($urandom_range(64, 1));
    if (r < 95) return 16'($urandom_range(1024, 1));
    return 16'($urandom_range(65535));
  endfunction

  // mostly frees of live blocks, some null, stray or off-by-one addresses
  task automatic random_free();
    int r, idx;
    bit [15:0] pa;
    r = $urandom_range(99);
    if (live_q.size() > 0 && r < 85) begin
      idx = $urandom_range(live_q.size() - 1);
      pa = live_q[idx];
      live_q.delete(idx);
    end else if (r < 90) begin
      pa = '0;
    end else if (r < 95 && live_q.size() > 0) begin
      pa = live_q[0] + 16'd1;
    end else begin
      pa = 16'($urandom_range(65535));
    end
    put_beat(ACT_FREE, '0, pa);
  endtask

  initial begin
    logic [16:0] limits[6];
    int idle_mode[4][2];
    int alloc_pct;

    limits = '{17'd65536, 17'd0, 17'd131071, 17'd2000, 17'd700, 17'd65536};
    idle_mode = '{'{0, 0}, '{63, 0}, '{0, 63}, '{28, 28}};

    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: bad size, exhaustion, fits, splits, merges, bad frees, shrink
    put_beat(ACT_ALLOC, 16'd0, '0);
    put_beat(ACT_ALLOC, 16'hFFFF, '0);
    put_beat(ACT_ALLOC, 16'd100, '0);
    put_beat(ACT_ALLOC, 16'd50, '0);
    put_beat(ACT_ALLOC, 16'd200, '0);
    put_beat(ACT_FREE, '0, 16'd132);
    put_beat(ACT_FREE, '0, 16'd132);
    put_beat(ACT_ALLOC, 16'd50, '0);
    put_beat(ACT_FREE, '0, 16'd16);
    put_beat(ACT_FREE, '0, 16'd132);
    put_beat(ACT_ALLOC, 16'd20, '0);
    put_beat(ACT_ALLOC, 16'd10, '0);
    put_beat(ACT_FREE, '0, 16'd0);
    put_beat(ACT_FREE, '0, 16'd1);
    put_beat(ACT_FREE, '0, 16'hFFFF);
    put_beat(ACT_FREE, '0, 16'd198);
    put_beat(ACT_ALLOC, 16'hFFF0, '0);
    put_beat(ACT_FREE, '0, 16'd16);
    put_beat(ACT_FREE, '0, 16'd52);
    put_beat(ACT_FREE, '0, 16'd16);
    settle();
    live_q.delete();

    // random phases, each with a heap limit from limits and an idle/stall mix from idle_mode
    for (int ph = 0; ph < 6; ph++) begin
      set_limit(limits[ph]);
      idle_pct = idle_mode[ph % 4][0];
      stall_pct = idle_mode[ph % 4][1];
      alloc_pct = (ph % 2 == 0) ? 80 : 55;
      if (ph == 2) hold_go = 1;
      for (int i = 0; i < 160; i++) begin
        if ($urandom_range(99) < alloc_pct) put_beat(ACT_ALLOC, pick_size(), '0);
        else random_free();
      end
      // release everything so the heap shrinks back
      settle();
      while (live_q.size() > 0) put_beat(ACT_FREE, '0, live_q.pop_back());
      settle();
    end

    $display("ran %0d requests over 6 heap limits: ok %0d, bad size %0d, no heap %0d,",
             n_beats, st_seen[0], st_seen[1], st_seen[2]);
    $display("bad address %0d, table full %0d", st_seen[3], st_seen[4]);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 800000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bfha_pkg.sv
rtl/core/bfha_cell.sv
rtl/core/best_fit_heap_allocator_core.sv
rtl/core/bfha_checker.sv
tb/bfha_checker.sv
tb/tb_best_fit_heap_allocator_core.sv
